>>> sv/s2x_pkg.sv
// ----------------------------------------------------------------------------
// s2x_pkg
// Shared types, register codes and averaging functions of the Super2xSaI
// pixel scaler.
// ----------------------------------------------------------------------------
package s2x_pkg;

  localparam int unsigned PixW = 32;

  typedef logic [PixW-1:0] pix_t;
  typedef pix_t [3:0] col_t;  // rows y-1 .. y+2

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t RegHalfColor    = 2'd0;
  localparam reg_idx_t RegHalfCarry    = 2'd1;
  localparam reg_idx_t RegQuarterColor = 2'd2;
  localparam reg_idx_t RegQuarterCarry = 2'd3;

  localparam pix_t HalfColorRst    = 32'h00FE_FEFE;
  localparam pix_t HalfCarryRst    = 32'h0001_0101;
  localparam pix_t QuarterColorRst = 32'h00FC_FCFC;
  localparam pix_t QuarterCarryRst = 32'h0003_0303;

  localparam logic [1:0] HeldMax = 2'd3;

  typedef struct packed {
    pix_t half_color;
    pix_t half_carry;
    pix_t quarter_color;
    pix_t quarter_carry;
  } masks_t;

  typedef struct packed {
    col_t [3:0] cols;  // columns x-1 .. x+2
    logic       eor;
  } job_t;

  typedef struct packed {
    pix_t tl;
    pix_t tr;
    pix_t bl;
    pix_t br;
    logic eor;
  } blk_t;

  function automatic pix_t avg2(pix_t a, pix_t b, pix_t color, pix_t carry);
    return ((a & color) >> 1) + ((b & color) >> 1) + (a & b & carry);
  endfunction

  function automatic pix_t avg4(pix_t a, pix_t b, pix_t c, pix_t d, pix_t m, pix_t q);
    pix_t hi;
    pix_t lo;
    hi = ((a & m) >> 2) + ((b & m) >> 2) + ((c & m) >> 2) + ((d & m) >> 2);
    lo = (((a & q) + (b & q) + (c & q) + (d & q)) >> 2) & q;
    return hi + lo;
  endfunction

endpackage

>>> sv/s2x_fifo.sv
// ----------------------------------------------------------------------------
// s2x_fifo
// Small register FIFO with occupancy count; Depth must be a power of two.
// ----------------------------------------------------------------------------
module s2x_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [Width-1:0]               data_i,
  input  logic                           pop_i,
  output logic [Width-1:0]               data_o,
  output logic                           full_o,
  output logic                           empty_o,
  output logic [$clog2(Depth+1)-1:0]     count_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth+1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wptr_q, wptr_d;
  logic [AddrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = wptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rptr_d = rptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> sv/s2x_front.sv
// ----------------------------------------------------------------------------
// s2x_front
// Column window with edge clamping; turns each accepted column into block
// jobs; replays right-edge flush jobs one per cycle while job_ready_i is high.
// ----------------------------------------------------------------------------
module s2x_front import s2x_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  col_t col_i,
  input  logic row_first_i,
  input  logic row_last_i,
  output logic job_valid_o,
  output job_t job_o,
  input  logic job_ready_i
);

  col_t [2:0] win_q, win_d;
  col_t       cur_q, cur_d;
  logic [1:0] held_q, held_d;
  logic [1:0] flush_q, flush_d;

  col_t [2:0] wp;
  logic [1:0] held_e;
  logic [1:0] remain;
  logic       accept;
  logic       flushing;

  assign full_o   = (flush_q != 2'd0) || !job_ready_i;
  assign accept   = push_i && !full_o;
  assign flushing = (flush_q != 2'd0) && job_ready_i;
  assign held_e   = row_first_i ? 2'd0 : held_q;

  always_comb begin
    if (held_e == 2'd0) begin
      wp = {col_i, col_i, col_i};
    end else if (row_last_i && held_e == 2'd1) begin
      wp = {col_i, win_q[2], win_q[1]};
    end else begin
      wp = win_q;
    end

    if (!row_last_i) begin
      remain = 2'd0;
    end else if (held_e >= 2'd2) begin
      remain = 2'd2;
    end else if (held_e == 2'd1) begin
      remain = 2'd1;
    end else begin
      remain = 2'd0;
    end
  end

  always_comb begin
    win_d       = win_q;
    cur_d       = cur_q;
    held_d      = held_q;
    flush_d     = flush_q;
    job_valid_o = 1'b0;
    job_o.cols  = {cur_q, win_q[2], win_q[1], win_q[0]};
    job_o.eor   = (flush_q == 2'd1);

    if (accept) begin
      job_valid_o = row_last_i || (held_e >= 2'd2);
      job_o.cols  = {col_i, wp[2], wp[1], wp[0]};
      job_o.eor   = row_last_i && (remain == 2'd0);
      win_d       = {col_i, wp[2], wp[1]};
      cur_d       = col_i;
      flush_d     = remain;
      if (row_last_i) begin
        held_d = 2'd0;
      end else if (held_e < HeldMax) begin
        held_d = held_e + 2'd1;
      end else begin
        held_d = HeldMax;
      end
    end else if (flushing) begin
      job_valid_o = 1'b1;
      win_d       = {cur_q, win_q[2], win_q[1]};
      flush_d     = flush_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 2'd0;
      flush_q <= 2'd0;
    end else begin
      held_q  <= held_d;
      flush_q <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    cur_q <= cur_d;
  end

endmodule

>>> sv/s2x_back.sv
// ----------------------------------------------------------------------------
// s2x_back
// Two-stage block kernel: stage 1 registers the equality tests, the vote
// and all averaging candidates; stage 2 picks the four output pixels.
// ----------------------------------------------------------------------------
module s2x_back import s2x_pkg::*; #(
  parameter int unsigned OutDepth = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  masks_t                        masks_i,
  input  logic                          job_valid_i,
  input  job_t                          job_i,
  output logic                          job_pop_o,
  input  logic [$clog2(OutDepth+1)-1:0] out_count_i,
  output logic                          blk_valid_o,
  output blk_t                          blk_o
);

  localparam int unsigned CntW = $clog2(OutDepth+1) + 1;

  typedef struct packed {
    pix_t p5;
    pix_t p6;
    pix_t p9;
    pix_t a56;
    pix_t a910;
    pix_t a95;
    pix_t q10;
    pix_t q9;
    pix_t q6;
    pix_t q5;
    logic f96;
    logic f510;
    logic vote_gt;
    logic vote_lt;
    logic br_c1;
    logic br_c2;
    logic tr_c1;
    logic tr_c2;
    logic bl_c;
    logic tl_c;
    logic eor;
  } s1_t;

  pix_t       p [16];
  s1_t        s1_d, s1_q;
  logic       s1_v_q;
  logic [3:0] pos_v, neg_v;
  logic [2:0] pos_n, neg_n;
  pix_t       tr, br;

  assign job_pop_o = job_valid_i &&
                     ((CntW'(out_count_i) + CntW'(s1_v_q)) < CntW'(OutDepth));

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 4; k++) begin
        p[r*4+k] = job_i.cols[k][r];
      end
    end
  end

  always_comb begin
    pos_v[0] = (p[6] != p[8])  || (p[6] != p[13]);
    pos_v[1] = (p[6] != p[4])  || (p[6] != p[1]);
    pos_v[2] = (p[6] != p[14]) || (p[6] != p[11]);
    pos_v[3] = (p[6] != p[2])  || (p[6] != p[7]);
    neg_v[0] = (p[5] != p[8])  || (p[5] != p[13]);
    neg_v[1] = (p[5] != p[4])  || (p[5] != p[1]);
    neg_v[2] = (p[5] != p[14]) || (p[5] != p[11]);
    neg_v[3] = (p[5] != p[2])  || (p[5] != p[7]);
    pos_n    = 3'($countones(pos_v));
    neg_n    = 3'($countones(neg_v));

    s1_d.p5   = p[5];
    s1_d.p6   = p[6];
    s1_d.p9   = p[9];
    s1_d.a56  = avg2(p[5], p[6], masks_i.half_color, masks_i.half_carry);
    s1_d.a910 = avg2(p[9], p[10], masks_i.half_color, masks_i.half_carry);
    s1_d.a95  = avg2(p[9], p[5], masks_i.half_color, masks_i.half_carry);
    s1_d.q10  = avg4(p[10], p[10], p[10], p[9],
                     masks_i.quarter_color, masks_i.quarter_carry);
    s1_d.q9   = avg4(p[9], p[9], p[9], p[10],
                     masks_i.quarter_color, masks_i.quarter_carry);
    s1_d.q6   = avg4(p[6], p[6], p[6], p[5],
                     masks_i.quarter_color, masks_i.quarter_carry);
    s1_d.q5   = avg4(p[6], p[5], p[5], p[5],
                     masks_i.quarter_color, masks_i.quarter_carry);
    s1_d.f96     = (p[9] == p[6]);
    s1_d.f510    = (p[5] == p[10]);
    s1_d.vote_gt = (pos_n > neg_n);
    s1_d.vote_lt = (pos_n < neg_n);
    s1_d.br_c1 = (p[6] == p[10]) && (p[10] == p[13]) && (p[9] != p[14]) &&
                 (p[10] != p[12]);
    s1_d.br_c2 = (p[5] == p[9]) && (p[9] == p[14]) && (p[13] != p[10]) &&
                 (p[9] != p[15]);
    s1_d.tr_c1 = (p[6] == p[10]) && (p[6] == p[1]) && (p[5] != p[2]) &&
                 (p[6] != p[0]);
    s1_d.tr_c2 = (p[5] == p[9]) && (p[5] == p[2]) && (p[1] != p[6]) &&
                 (p[5] != p[3]);
    s1_d.bl_c = ((p[5] == p[10]) && (p[9] != p[6]) && (p[4] == p[5]) &&
                 (p[5] != p[14])) ||
                ((p[5] == p[8]) && (p[6] == p[5]) && (p[4] != p[9]) &&
                 (p[5] != p[12]));
    s1_d.tl_c = ((p[9] == p[6]) && (p[5] != p[10]) && (p[8] == p[9]) &&
                 (p[9] != p[2])) ||
                ((p[4] == p[9]) && (p[10] == p[9]) && (p[8] != p[5]) &&
                 (p[9] != p[0]));
    s1_d.eor = job_i.eor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= job_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      s1_q <= s1_d;
    end
  end

  always_comb begin
    if (s1_q.f96 && !s1_q.f510) begin
      tr = s1_q.p9;
      br = s1_q.p9;
    end else if (s1_q.f510 && !s1_q.f96) begin
      tr = s1_q.p5;
      br = s1_q.p5;
    end else if (s1_q.f510 && s1_q.f96) begin
      if (s1_q.vote_gt) begin
        tr = s1_q.p6;
      end else if (s1_q.vote_lt) begin
        tr = s1_q.p5;
      end else begin
        tr = s1_q.a56;
      end
      br = tr;
    end else begin
      if (s1_q.br_c1) begin
        br = s1_q.q10;
      end else if (s1_q.br_c2) begin
        br = s1_q.q9;
      end else begin
        br = s1_q.a910;
      end
      if (s1_q.tr_c1) begin
        tr = s1_q.q6;
      end else if (s1_q.tr_c2) begin
        tr = s1_q.q5;
      end else begin
        tr = s1_q.a56;
      end
    end

    blk_o.tl  = s1_q.tl_c ? s1_q.a95 : s1_q.p5;
    blk_o.tr  = tr;
    blk_o.bl  = s1_q.bl_c ? s1_q.a95 : s1_q.p9;
    blk_o.br  = br;
    blk_o.eor = s1_q.eor;
  end

  assign blk_valid_o = s1_v_q;

endmodule

>>> sv/super_2xsai_pixel_scaler.sv
// ----------------------------------------------------------------------------
// super_2xsai_pixel_scaler
// Path: a block passes through the job queue, the stage-1 register and the
//   result queue. Throughput: one column per cycle while the job queue has
//   room; after a row_last column, full stays high while the front window
//   issues the right-edge flush blocks, one per cycle while the queue has room.
// Reset: clears queues and row state; mask registers take their default values.
// Super2xSaI 2x upscaler: column window front, job queue, two-stage kernel,
// result queue.
// ----------------------------------------------------------------------------
module super_2xsai_pixel_scaler import s2x_pkg::*; #(
  parameter int unsigned JobDepth = 2,
  parameter int unsigned OutDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [31:0] pix_above_i,
  input  logic [31:0] pix_here_i,
  input  logic [31:0] pix_below_i,
  input  logic [31:0] pix_below_two_i,
  input  logic        row_first_i,
  input  logic        row_last_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] top_left_o,
  output logic [31:0] top_right_o,
  output logic [31:0] bottom_left_o,
  output logic [31:0] bottom_right_o,
  output logic        end_of_row_o
);

  masks_t masks_q, masks_d;

  col_t  col;
  logic  job_valid, job_pop, jq_full, jq_empty;
  job_t  job_in, job_out;
  logic  blk_valid;
  blk_t  blk_in, blk_out;
  logic  oq_full;
  logic [$clog2(JobDepth+1)-1:0] jq_count;
  logic [$clog2(OutDepth+1)-1:0] oq_count;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    masks_d = masks_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegHalfColor:    masks_d.half_color    = cfg_data_i;
        RegHalfCarry:    masks_d.half_carry    = cfg_data_i;
        RegQuarterColor: masks_d.quarter_color = cfg_data_i;
        RegQuarterCarry: masks_d.quarter_carry = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      masks_q.half_color    <= HalfColorRst;
      masks_q.half_carry    <= HalfCarryRst;
      masks_q.quarter_color <= QuarterColorRst;
      masks_q.quarter_carry <= QuarterCarryRst;
    end else begin
      masks_q <= masks_d;
    end
  end

  assign col = {pix_below_two_i, pix_below_i, pix_here_i, pix_above_i};

  s2x_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .col_i       (col),
    .row_first_i (row_first_i),
    .row_last_i  (row_last_i),
    .job_valid_o (job_valid),
    .job_o       (job_in),
    .job_ready_i (!jq_full)
  );

  s2x_fifo #(
    .Width ($bits(job_t)),
    .Depth (JobDepth)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .full_o  (jq_full),
    .empty_o (jq_empty),
    .count_o (jq_count)
  );

  s2x_back #(
    .OutDepth (OutDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .masks_i     (masks_q),
    .job_valid_i (!jq_empty && (jq_count != '0)),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_count_i (oq_count),
    .blk_valid_o (blk_valid),
    .blk_o       (blk_in)
  );

  s2x_fifo #(
    .Width ($bits(blk_t)),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (blk_valid && !oq_full),
    .data_i  (blk_in),
    .pop_i   (pop),
    .data_o  (blk_out),
    .full_o  (oq_full),
    .empty_o (empty),
    .count_o (oq_count)
  );

  assign top_left_o     = blk_out.tl;
  assign top_right_o    = blk_out.tr;
  assign bottom_left_o  = blk_out.bl;
  assign bottom_right_o = blk_out.br;
  assign end_of_row_o   = blk_out.eor;

endmodule

>>> tb/sv/super_2xsai_pixel_scaler_checker.sv
// ----------------------------------------------------------------------------
// super_2xsai_pixel_scaler_checker
// Watches the column, result and register channels of the Super2xSaI scaler.
// Keeps its own column window and mask copies, predicts the 2x2 output blocks
// from the accepted columns and compares each popped block, field by field,
// against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module super_2xsai_pixel_scaler_checker import s2x_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_valid_i,
  input  logic     cfg_ready_i,
  input  reg_idx_t cfg_index_i,
  input  pix_t     cfg_data_i,
  input  logic     push_i,
  input  logic     full_i,
  input  pix_t     pix_above_i,
  input  pix_t     pix_here_i,
  input  pix_t     pix_below_i,
  input  pix_t     pix_below_two_i,
  input  logic     row_first_i,
  input  logic     row_last_i,
  input  logic     empty_i,
  input  logic     pop_i,
  input  pix_t     top_left_i,
  input  pix_t     top_right_i,
  input  pix_t     bottom_left_i,
  input  pix_t     bottom_right_i,
  input  logic     end_of_row_i,
  output int       error_count_o,
  output int       pending_o
);

  pix_t       half_color;
  pix_t       half_carry;
  pix_t       quarter_color;
  pix_t       quarter_carry;
  col_t       window [3];  // oldest column first
  logic [1:0] held;
  blk_t       expected_blocks [$];
  int         mismatches = 0;

  assign error_count_o = mismatches;

  function automatic pix_t mean_of_two(pix_t a, pix_t b);
    return ((a & half_color) >> 1) + ((b & half_color) >> 1) + (a & b & half_carry);
  endfunction

  function automatic pix_t mean_of_four(pix_t a, pix_t b, pix_t c, pix_t d);
    pix_t hi;
    pix_t lo;
    hi = ((a & quarter_color) >> 2) + ((b & quarter_color) >> 2)
       + ((c & quarter_color) >> 2) + ((d & quarter_color) >> 2);
    lo = (((a & quarter_carry) + (b & quarter_carry) + (c & quarter_carry)
         + (d & quarter_carry)) >> 2) & quarter_carry;
    return hi + lo;
  endfunction

  function automatic int vote(pix_t a, pix_t b, pix_t c, pix_t d);
    return int'(a != c || a != d) - int'(b != c || b != d);
  endfunction

  // c0..c3 are columns x-1 .. x+2; p[] is the 4x4 window in row-major order
  function automatic blk_t scale_block(col_t c0, col_t c1, col_t c2, col_t c3, logic eor);
    pix_t p [16];
    col_t cs [4];
    blk_t b;
    int   s;
    cs[0] = c0;
    cs[1] = c1;
    cs[2] = c2;
    cs[3] = c3;
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 4; k++) begin
        p[r*4 + k] = cs[k][r];
      end
    end

    if (p[9] == p[6] && p[5] != p[10]) begin
      b.br = p[9];
      b.tr = p[9];
    end else if (p[5] == p[10] && p[9] != p[6]) begin
      b.br = p[5];
      b.tr = p[5];
    end else if (p[5] == p[10] && p[9] == p[6]) begin
      s = vote(p[6], p[5], p[8], p[13]) + vote(p[6], p[5], p[4], p[1])
        + vote(p[6], p[5], p[14], p[11]) + vote(p[6], p[5], p[2], p[7]);
      if (s > 0) b.tr = p[6];
      else if (s < 0) b.tr = p[5];
      else b.tr = mean_of_two(p[5], p[6]);
      b.br = b.tr;
    end else begin
      if (p[6] == p[10] && p[10] == p[13] && p[9] != p[14] && p[10] != p[12])
        b.br = mean_of_four(p[10], p[10], p[10], p[9]);
      else if (p[5] == p[9] && p[9] == p[14] && p[13] != p[10] && p[9] != p[15])
        b.br = mean_of_four(p[9], p[9], p[9], p[10]);
      else
        b.br = mean_of_two(p[9], p[10]);
      if (p[6] == p[10] && p[6] == p[1] && p[5] != p[2] && p[6] != p[0])
        b.tr = mean_of_four(p[6], p[6], p[6], p[5]);
      else if (p[5] == p[9] && p[5] == p[2] && p[1] != p[6] && p[5] != p[3])
        b.tr = mean_of_four(p[6], p[5], p[5], p[5]);
      else
        b.tr = mean_of_two(p[5], p[6]);
    end

    if (p[5] == p[10] && p[9] != p[6] && p[4] == p[5] && p[5] != p[14])
      b.bl = mean_of_two(p[9], p[5]);
    else if (p[5] == p[8] && p[6] == p[5] && p[4] != p[9] && p[5] != p[12])
      b.bl = mean_of_two(p[9], p[5]);
    else
      b.bl = p[9];

    if (p[9] == p[6] && p[5] != p[10] && p[8] == p[9] && p[9] != p[2])
      b.tl = mean_of_two(p[9], p[5]);
    else if (p[4] == p[9] && p[10] == p[9] && p[8] != p[5] && p[9] != p[0])
      b.tl = mean_of_two(p[9], p[5]);
    else
      b.tl = p[5];

    b.eor = eor;
    return b;
  endfunction

  function automatic void scale_column(col_t cur, logic first, logic last);
    if (first) held = '0;
    if (held == 0) begin
      window[0] = cur;
      window[1] = cur;
      window[2] = cur;
    end
    if (held >= 2)
      expected_blocks.push_back(scale_block(window[0], window[1], window[2], cur, 1'b0));
    if (last) begin
      if (held >= 1)
        expected_blocks.push_back(scale_block(window[1], window[2], cur, cur, 1'b0));
      expected_blocks.push_back(scale_block(window[2], cur, cur, cur, 1'b1));
      held = '0;
    end else begin
      window[0] = window[1];
      window[1] = window[2];
      window[2] = cur;
      if (held < HeldMax) held = held + 2'd1;
    end
  endfunction

  function automatic void check_field(string field, pix_t want, pix_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    blk_t want;
    col_t cur;
    if (!rst_ni) begin
      half_color    = HalfColorRst;
      half_carry    = HalfCarryRst;
      quarter_color = QuarterColorRst;
      quarter_carry = QuarterCarryRst;
      held          = '0;
      expected_blocks.delete();
      pending_o     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegHalfColor:    half_color    = cfg_data_i;
          RegHalfCarry:    half_carry    = cfg_data_i;
          RegQuarterColor: quarter_color = cfg_data_i;
          RegQuarterCarry: quarter_carry = cfg_data_i;
          default: ;
        endcase
      end

      if (pop_i && !empty_i) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected block, expected none, got %h %h %h %h eor=%b", $time,
                   top_left_i, top_right_i, bottom_left_i, bottom_right_i, end_of_row_i);
          mismatches++;
        end else begin
          want = expected_blocks.pop_front();
          check_field("top_left", want.tl, top_left_i);
          check_field("top_right", want.tr, top_right_i);
          check_field("bottom_left", want.bl, bottom_left_i);
          check_field("bottom_right", want.br, bottom_right_i);
          check_field("end_of_row", pix_t'(want.eor), pix_t'(end_of_row_i));
        end
      end

      if (push_i && !full_i) begin
        cur[0] = pix_above_i;
        cur[1] = pix_here_i;
        cur[2] = pix_below_i;
        cur[3] = pix_below_two_i;
        scale_column(cur, row_first_i, row_last_i);
      end

      pending_o = expected_blocks.size();
    end
  end

endmodule

>>> tb/sv/super_2xsai_pixel_scaler_tb.sv
// ----------------------------------------------------------------------------
// super_2xsai_pixel_scaler_tb
// Drives source columns into the Super2xSaI scaler: a short directed set of
// edge rows, then random rows (well-formed, missing row start, restarted and
// noisy) over several mask settings. Both sides idle at random; the checker
// predicts and compares every output block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module super_2xsai_pixel_scaler_tb import s2x_pkg::*;;

  localparam int unsigned TimeoutCycles = 300000;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned PhaseColumns  = 45;

  logic     clk;
  logic     rst_n;
  logic     cfg_valid;
  logic     cfg_ready;
  reg_idx_t cfg_index;
  pix_t     cfg_data;
  logic     push;
  logic     full;
  pix_t     pix_above;
  pix_t     pix_here;
  pix_t     pix_below;
  pix_t     pix_below_two;
  logic     row_first;
  logic     row_last;
  logic     empty;
  logic     pop;
  pix_t     top_left;
  pix_t     top_right;
  pix_t     bottom_left;
  pix_t     bottom_right;
  logic     end_of_row;
  int       error_count;
  int       pending;

  int unsigned cycle_count = 0;
  int unsigned column_count = 0;
  int unsigned stall_left = 0;
  bit          src_gaps_on = 1'b1;
  bit          sink_gaps_on = 1'b1;
  pix_t        palette [4];
  int unsigned palette_size = 4;

  super_2xsai_pixel_scaler dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .push            (push),
    .full            (full),
    .pix_above_i     (pix_above),
    .pix_here_i      (pix_here),
    .pix_below_i     (pix_below),
    .pix_below_two_i (pix_below_two),
    .row_first_i     (row_first),
    .row_last_i      (row_last),
    .empty           (empty),
    .pop             (pop),
    .top_left_o      (top_left),
    .top_right_o     (top_right),
    .bottom_left_o   (bottom_left),
    .bottom_right_o  (bottom_right),
    .end_of_row_o    (end_of_row)
  );

  super_2xsai_pixel_scaler_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .push_i          (push),
    .full_i          (full),
    .pix_above_i     (pix_above),
    .pix_here_i      (pix_here),
    .pix_below_i     (pix_below),
    .pix_below_two_i (pix_below_two),
    .row_first_i     (row_first),
    .row_last_i      (row_last),
    .empty_i         (empty),
    .pop_i           (pop),
    .top_left_i      (top_left),
    .top_right_i     (top_right),
    .bottom_left_i   (bottom_left),
    .bottom_right_i  (bottom_right),
    .end_of_row_i    (end_of_row),
    .error_count_o   (error_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TimeoutCycles) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        stall_left = pick_gap(sink_gaps_on);
      end
    end
  end

  function automatic void new_palette();
    int unsigned r;
    palette_size = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) palette[i] = '0;
      else if (r == 1) palette[i] = '1;
      else if (r == 2 && i > 0) palette[i] = palette[i-1] ^ pix_t'(1 << $urandom_range(0, 31));
      else palette[i] = $urandom;
    end
  endfunction

  function automatic pix_t pick_pixel();
    if ($urandom_range(0, 99) < 85) return palette[$urandom_range(0, palette_size - 1)];
    return $urandom;
  endfunction

  // entered and left at a falling edge; push stays high for back-to-back columns
  task automatic send_column(pix_t a, pix_t h, pix_t b, pix_t b2, logic first, logic last);
    int unsigned gap;
    gap = pick_gap(src_gaps_on);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push          <= 1'b1;
    pix_above     <= a;
    pix_here      <= h;
    pix_below     <= b;
    pix_below_two <= b2;
    row_first     <= first;
    row_last      <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    column_count++;
    @(negedge clk);
  endtask

  task automatic send_row(int unsigned width, bit with_first, bit with_last);
    new_palette();
    for (int unsigned c = 0; c < width; c++) begin
      send_column(pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel(),
                  with_first && c == 0, with_last && c == width - 1);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(reg_idx_t idx, pix_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_masks(pix_t hcol, pix_t hcar, pix_t qcol, pix_t qcar);
    write_reg(RegHalfColor, hcol);
    write_reg(RegHalfCarry, hcar);
    write_reg(RegQuarterColor, qcol);
    write_reg(RegQuarterCarry, qcar);
    cfg_valid <= 1'b0;
  endtask

  function automatic int unsigned pick_width();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 16);
    return $urandom_range(17, 40);
  endfunction

  task automatic run_random(int unsigned columns);
    int unsigned r;
    int unsigned target;
    target = column_count + columns;
    while (column_count < target) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_row(pick_width(), 1'b1, 1'b1);
      end else if (r < 85) begin
        send_row(pick_width(), 1'b0, 1'b1);  // no row start after previous row end
      end else if (r < 93) begin
        send_row($urandom_range(1, 6), 1'b1, 1'b0);  // dropped by the next row start
      end else begin
        repeat ($urandom_range(1, 4))
          send_column(pick_pixel(), pick_pixel(), pick_pixel(), pick_pixel(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
    send_row($urandom_range(1, 3), 1'b1, 1'b1);
  endtask

  initial begin
    pix_t ca;
    pix_t cb;
    cfg_valid     = 1'b0;
    cfg_index     = RegHalfColor;
    cfg_data      = '0;
    push          = 1'b0;
    pix_above     = '0;
    pix_here      = '0;
    pix_below     = '0;
    pix_below_two = '0;
    row_first     = 1'b0;
    row_last      = 1'b0;
    rst_n         = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-column rows at the extremes
    send_column('1, '1, '1, '1, 1'b1, 1'b1);
    send_column('0, '0, '0, '0, 1'b1, 1'b1);
    // two-column row
    send_column('0, '1, '0, '1, 1'b1, 1'b0);
    send_column('1, '0, '1, '0, 1'b0, 1'b1);
    // checkerboard drives the vote path
    ca = 32'h00FF_00FF;
    cb = 32'h0000_FF00;
    for (int c = 0; c < 5; c++) begin
      if (c % 2 == 0) send_column(ca, cb, ca, cb, c == 0, c == 4);
      else send_column(cb, ca, cb, ca, 1'b0, c == 4);
    end
    // flat row
    for (int c = 0; c < 3; c++) send_column(32'h0080_8080, 32'h0080_8080, 32'h0080_8080,
                                           32'h0080_8080, c == 0, c == 2);
    // row restarted in mid row
    send_column(ca, ca, cb, cb, 1'b1, 1'b0);
    send_column(cb, ca, ca, cb, 1'b0, 1'b0);
    send_column(ca, cb, cb, cb, 1'b1, 1'b0);
    send_column(cb, ca, cb, cb, 1'b0, 1'b0);
    send_column(cb, cb, ca, cb, 1'b0, 1'b1);
    // new row with no row start
    send_column(32'h1234_5678, 32'hDEAD_BEEF, 32'h1234_5678, 32'hDEAD_BEEF, 1'b0, 1'b0);
    send_column(32'hDEAD_BEEF, 32'h1234_5678, 32'hDEAD_BEEF, 32'h1234_5678, 1'b0, 1'b1);
    wait_idle();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1: write_masks('0, '0, '0, '0);
        2: write_masks('1, '1, '1, '1);
        3, 5: write_masks($urandom, $urandom, $urandom, $urandom);
        4: write_masks(HalfColorRst, HalfCarryRst, QuarterColorRst, QuarterCarryRst);
        default: ;
      endcase
      src_gaps_on  = (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      sink_gaps_on = (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      run_random(PhaseColumns);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/s2x_pkg.sv
sv/s2x_fifo.sv
sv/s2x_front.sv
sv/s2x_back.sv
sv/super_2xsai_pixel_scaler.sv
tb/sv/super_2xsai_pixel_scaler_checker.sv
tb/sv/super_2xsai_pixel_scaler_tb.sv
